/* hw/rtl/bdq_pkg.sv */
// Package for the bounded deque core: operation and status codes, payload
// structs, and the command/status structs between controller and datapath.
// No dependencies.
package bdq_pkg;

    // Default ring depth.
    localparam int DQ_CAPACITY = 16;

    // Operation codes carried in the op field.
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [2:0] OP_PEEK_BACK  = 3'd5;
    localparam logic [2:0] OP_CLEAR      = 3'd6;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // One input word.
    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
    } t_dq_in;

    // One result word.
    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic [4:0]         occupancy;
    } t_dq_out;

    // Action issued by the controller to the datapath.
    typedef struct packed {
        logic ins_front;
        logic ins_back;
        logic rem_front;
        logic rem_back;
        logic peek_front;
        logic peek_back;
        logic clear;
    } t_dq_cmd;

    // Fill status reported by the datapath.
    typedef struct packed {
        logic empty;
        logic full;
    } t_dq_stat;

endpackage

/* hw/rtl/bdq_ctrl.sv */
// Controller of the bounded deque: decodes the operation against the fill
// status, issues the datapath action and strobes the result.
// Depends on bdq_pkg.
module bdq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [2:0]        i_op,
    input  bdq_pkg::t_dq_stat i_stat,
    output bdq_pkg::t_dq_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_done,
    output logic [1:0]        o_status
);
    import bdq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RESP
    } t_state;

    t_state     r_state;
    logic       r_done;
    logic [1:0] r_status;
    logic       w_accept;
    t_dq_cmd    w_cmd;
    logic [1:0] w_status;

    // A word is taken only while no result is pending.
    assign o_busy   = (r_state == S_RESP);
    assign w_accept = i_start && !o_busy;

    // Decode the operation; full and empty cases turn into no action.
    always_comb begin
        w_cmd    = '0;
        w_status = ST_OK;
        unique case (i_op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (i_stat.full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.ins_front = (i_op == OP_PUSH_FRONT);
                    w_cmd.ins_back  = (i_op == OP_PUSH_BACK);
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
                if (i_stat.empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_cmd.rem_front  = (i_op == OP_POP_FRONT);
                    w_cmd.rem_back   = (i_op == OP_POP_BACK);
                    w_cmd.peek_front = (i_op == OP_PEEK_FRONT);
                    w_cmd.peek_back  = (i_op == OP_PEEK_BACK);
                end
            end
            OP_CLEAR: begin
                w_cmd.clear = 1'b1;
            end
            default: begin
                w_cmd = '0;
            end
        endcase
    end

    // Actions fire only on an accepted word.
    assign o_cmd = w_accept ? w_cmd : '0;

    // State and the registered result strobe and status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_status <= ST_OK;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state  <= S_RESP;
                        r_done   <= 1'b1;
                        r_status <= w_status;
                    end
                end
                S_RESP: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b0;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_status = r_status;

endmodule

/* hw/rtl/bdq_datapath.sv */
// Datapath of the bounded deque: ring memory, front and back indices and
// the word count. Executes one action per command from the controller.
// Depends on bdq_pkg.
module bdq_datapath #(
    parameter int CAPACITY = bdq_pkg::DQ_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [31:0] i_value,
    input  bdq_pkg::t_dq_cmd   i_cmd,
    output bdq_pkg::t_dq_stat  o_stat,
    output logic signed [31:0] o_data,
    output logic [4:0]         o_occupancy
);
    import bdq_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_rd_data;
    logic               r_rd_used;
    logic [IW-1:0]      r_front;
    logic [IW-1:0]      r_back;
    logic [CW-1:0]      r_count;

    logic [IW-1:0] w_front_prev;
    logic [IW-1:0] w_front_next;
    logic [IW-1:0] w_back_prev;
    logic [IW-1:0] w_back_next;
    logic          w_we;
    logic          w_re;
    logic [IW-1:0] w_waddr;
    logic [IW-1:0] w_raddr;

    // Ring neighbors of both ends.
    assign w_front_prev = (r_front == '0) ? LAST_IDX : r_front - 1'b1;
    assign w_front_next = (r_front == LAST_IDX) ? '0 : r_front + 1'b1;
    assign w_back_prev  = (r_back == '0) ? LAST_IDX : r_back - 1'b1;
    assign w_back_next  = (r_back == LAST_IDX) ? '0 : r_back + 1'b1;

    // The back index points one past the last word.
    assign w_we    = i_cmd.ins_front || i_cmd.ins_back;
    assign w_waddr = i_cmd.ins_front ? w_front_prev : r_back;
    assign w_re    = i_cmd.rem_front || i_cmd.peek_front
                  || i_cmd.rem_back || i_cmd.peek_back;
    assign w_raddr = (i_cmd.rem_front || i_cmd.peek_front) ? r_front : w_back_prev;

    // Ring memory with registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= i_value;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // Indices and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_back    <= '0;
            r_count   <= '0;
            r_rd_used <= 1'b0;
        end else begin
            r_rd_used <= w_re;
            if (i_cmd.clear) begin
                r_front <= '0;
                r_back  <= '0;
                r_count <= '0;
            end else if (i_cmd.ins_front) begin
                r_front <= w_front_prev;
                r_count <= r_count + 1'b1;
            end else if (i_cmd.ins_back) begin
                r_back  <= w_back_next;
                r_count <= r_count + 1'b1;
            end else if (i_cmd.rem_front) begin
                r_front <= w_front_next;
                r_count <= r_count - 1'b1;
            end else if (i_cmd.rem_back) begin
                r_back  <= w_back_prev;
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Read data shows only in the cycle after a read; every other result reads zero.
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_data       = r_rd_used ? r_rd_data : '0;
    assign o_occupancy  = 5'(r_count);

endmodule

/* hw/rtl/bounded_deque_core.sv */
// Bounded deque core: a word is accepted when start is high and busy is low.
// Its result is strobed on o_done in the next cycle; busy is high in that
// cycle, so no new word is taken while a result is pending. The receiver
// cannot stall. Synchronous reset empties the deque; ring memory contents
// are not cleared.
module bounded_deque_core #(
    parameter int CAPACITY = bdq_pkg::DQ_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  bdq_pkg::t_dq_in  i_item,
    output logic             busy,
    output logic             o_done,
    output bdq_pkg::t_dq_out o_result
);
    import bdq_pkg::*;

    t_dq_cmd            w_cmd;
    t_dq_stat           w_stat;
    logic signed [31:0] w_data;
    logic [1:0]         w_status;
    logic [4:0]         w_occ;

    // Controller: handshake, decode and result strobe.
    bdq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_item.op),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_status (w_status)
    );

    // Datapath: ring memory and pointers.
    bdq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_item.value),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_data      (w_data),
        .o_occupancy (w_occ)
    );

    assign o_result.data      = w_data;
    assign o_result.status    = w_status;
    assign o_result.occupancy = w_occ;

endmodule

/* hw/rtl/bdq_checker.sv */
// Port-level checker for the bounded deque core, bound to the top level.
// Depends on bdq_pkg.
module bdq_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input bdq_pkg::t_dq_out o_result
);
    import bdq_pkg::*;

    // Every accepted word gives its result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("accepted word did not produce a result");

    // A result strobe lasts one cycle and blocks new words meanwhile.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy ##1 !o_done)
        else $error("result strobe not single or not busy");

    // An empty read returns zero.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_EMPTY) |-> (o_result.data == '0))
        else $error("empty status with nonzero data");

    // Every strobed result carries one of the defined status codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status == ST_OK || o_result.status == ST_EMPTY
                    || o_result.status == ST_FULL))
        else $error("undefined status code");

endmodule

bind bounded_deque_core bdq_checker u_bdq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
